@@ src/asg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_pkg
// Shared widths, phase codes, queue and step records, and the block span helper
// of the allreduce schedule generator.
// ----------------------------------------------------------------------------
package asg_pkg;

   localparam int GS_W          = 11;
   localparam int RANK_W        = 10;
   localparam int CNT_W         = 31;
   localparam int PHASE_W       = 3;
   localparam int POF_W         = 11;
   localparam int LOG_W         = 4;
   localparam int REM_W         = 10;
   localparam int IDX_W         = 12;
   localparam int PROD_W        = IDX_W + CNT_W;
   localparam int MAX_PROCS_DEF = 1024;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_PRE  = 3'd0,
      PHASE_RS   = 3'd1,
      PHASE_AG   = 3'd2,
      PHASE_POST = 3'd3,
      PHASE_DONE = 3'd4
   } phase_type;

   typedef struct packed {
      logic              bad;
      logic              fold_even;
      logic              fold_odd;
      logic              reduce;
      logic [RANK_W-1:0] rank;
      logic [RANK_W-1:0] nr;
      logic [REM_W-1:0]  rem;
      logic [POF_W-1:0]  pof2;
      logic [CNT_W-1:0]  q;
      logic [REM_W-1:0]  r;
   } job_type;

   typedef struct packed {
      phase_type         phase;
      logic [RANK_W-1:0] peer;
      logic [IDX_W-1:0]  send_blk;
      logic [IDX_W-1:0]  send_len;
      logic              send_tail;
      logic [IDX_W-1:0]  recv_blk;
      logic [IDX_W-1:0]  recv_len;
      logic              recv_tail;
      logic              recv_to_temp;
      logic              do_reduce;
      logic              status;
      logic              last;
      logic [CNT_W-1:0]  q;
      logic [REM_W-1:0]  r;
   } step_type;

   typedef struct packed {
      logic [IDX_W-1:0] len;
      logic             tail;
   } span_type;

   // Blocks in [a, b), b clipped to pof2; tail set when the last block is included.
   function automatic span_type span_of(input logic [IDX_W-1:0] a,
                                        input logic [IDX_W-1:0] b,
                                        input logic [POF_W-1:0] pof2);
      logic [IDX_W-1:0] p;
      logic [IDX_W-1:0] bc;
      span_type         s;
      p      = IDX_W'(pof2);
      bc     = (b > p) ? p : b;
      s.len  = (bc > a) ? bc - a : '0;
      s.tail = (bc > a) && (bc == p);
      return s;
   endfunction

endpackage

@@ src/asg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_front
// Request intake: validates the group, derives pof2, fold role, folded rank,
// block size and remainder, and pushes the classified request to the queue.
// ----------------------------------------------------------------------------
module asg_front
   import asg_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [GS_W-1:0]   req_group_size,
   input  logic [RANK_W-1:0] req_my_rank,
   input  logic [CNT_W-1:0]  req_elem_count,
   input  logic              req_reduce_enable,
   input  logic              queue_full,
   output logic              push,
   output job_type           push_job
);

   logic [LOG_W-1:0] lg;
   logic [POF_W-1:0] pof2;
   logic [REM_W-1:0] rem;
   logic             in_fold;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      lg = '0;
      for (int i = 0; i < GS_W; i++) begin
         if (req_group_size[i]) lg = LOG_W'(i);
      end
      pof2    = POF_W'(1) << lg;
      rem     = REM_W'(req_group_size - GS_W'(pof2));
      in_fold = GS_W'(req_my_rank) < {rem, 1'b0};

      push_job.bad       = (req_group_size == '0) ||
                           (32'(req_group_size) > 32'(MAX_PROCS)) ||
                           (GS_W'(req_my_rank) >= req_group_size);
      push_job.fold_even = in_fold && !req_my_rank[0];
      push_job.fold_odd  = in_fold && req_my_rank[0];
      push_job.reduce    = req_reduce_enable;
      push_job.rank      = req_my_rank;
      push_job.nr        = in_fold ? (req_my_rank >> 1) : req_my_rank - rem;
      push_job.rem       = rem;
      push_job.pof2      = pof2;
      push_job.q         = req_elem_count >> lg;
      push_job.r         = req_elem_count[REM_W-1:0] & REM_W'(pof2 - POF_W'(1));
   end

endmodule

@@ src/asg_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_queue
// Short FIFO of classified requests between intake and the step sequencer.
// ----------------------------------------------------------------------------
module asg_queue
   import asg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    job_valid,
   output job_type job,
   input  logic    pop
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full      = fill_ff == FILL_W'(DEPTH);
   assign job_valid = fill_ff != '0;
   assign job       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) fill_in = fill_ff + FILL_W'(1);
      else if (pop && !push) fill_in = fill_ff - FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

@@ src/asg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_back
// Step sequencer: walks pre-exchange, reduce-scatter, allgather, post-exchange
// and done for one request, in block units, one step per cycle when unstalled.
// ----------------------------------------------------------------------------
module asg_back
   import asg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job,
   output logic     pop,
   output logic     step_valid,
   output step_type step,
   input  logic     step_stall
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PRE  = 6'b000010,
      ST_RS   = 6'b000100,
      ST_AG   = 6'b001000,
      ST_POST = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [POF_W-1:0]  mask_ff, mask_in;
   logic [POF_W-1:0]  half_ff, half_in;
   logic [IDX_W-1:0]  send_ff, send_in;
   logic [IDX_W-1:0]  recv_ff, recv_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic              step_valid_ff, step_valid_in;
   step_type          step_ff, step_in;

   logic              slot_free;
   logic              emit;
   logic              bit_hi;
   logic [RANK_W-1:0] newdst;
   logic [RANK_W-1:0] peer_x;
   logic [IDX_W-1:0]  half_i;
   logic [IDX_W-1:0]  pof_i;
   logic [IDX_W-1:0]  s_idx;
   logic [IDX_W-1:0]  r_idx;
   logic [IDX_W-1:0]  l_new;
   span_type          sp_s;
   span_type          sp_r;
   step_type          step_n;

   assign slot_free  = !step_valid_ff || !step_stall;
   assign pop        = (state_ff == ST_IDLE) && job_valid;
   assign step_valid = step_valid_ff;
   assign step       = step_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      mask_in  = mask_ff;
      half_in  = half_ff;
      send_in  = send_ff;
      recv_in  = recv_ff;
      last_in  = last_ff;
      emit     = 1'b0;
      s_idx    = '0;
      r_idx    = '0;
      l_new    = last_ff;
      sp_s     = '0;
      sp_r     = '0;

      half_i = IDX_W'(half_ff);
      pof_i  = IDX_W'(job_ff.pof2);
      bit_hi = |(job_ff.nr & RANK_W'(mask_ff));
      newdst = job_ff.nr ^ RANK_W'(mask_ff);
      peer_x = (newdst < job_ff.rem) ? RANK_W'({newdst, 1'b1}) : newdst + job_ff.rem;

      step_n   = '0;
      step_n.q = job_ff.q;
      step_n.r = job_ff.r;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in  = job;
               mask_in = POF_W'(1);
               half_in = job.pof2 >> 1;
               send_in = '0;
               recv_in = '0;
               last_in = IDX_W'(job.pof2);
               if (job.bad) state_in = ST_DONE;
               else if (job.fold_even || job.fold_odd) state_in = ST_PRE;
               else if (job.pof2 > POF_W'(1)) state_in = ST_RS;
               else state_in = ST_DONE;
            end
         end
         ST_PRE: begin
            emit         = 1'b1;
            step_n.phase = PHASE_PRE;
            if (job_ff.fold_even) begin
               step_n.peer      = job_ff.rank + RANK_W'(1);
               step_n.send_len  = pof_i;
               step_n.send_tail = 1'b1;
            end else begin
               step_n.peer         = job_ff.rank - RANK_W'(1);
               step_n.recv_len     = pof_i;
               step_n.recv_tail    = 1'b1;
               step_n.recv_to_temp = 1'b1;
               step_n.do_reduce    = job_ff.reduce;
            end
            if (slot_free) state_in = job_ff.fold_odd ? ST_RS : ST_POST;
         end
         ST_RS: begin
            emit = 1'b1;
            if (!bit_hi) begin
               s_idx = recv_ff + half_i;
               r_idx = recv_ff;
               sp_s  = span_of(s_idx, last_ff, job_ff.pof2);
               sp_r  = span_of(recv_ff, s_idx, job_ff.pof2);
            end else begin
               s_idx = send_ff;
               r_idx = send_ff + half_i;
               sp_s  = span_of(send_ff, r_idx, job_ff.pof2);
               sp_r  = span_of(r_idx, last_ff, job_ff.pof2);
            end
            step_n.phase        = PHASE_RS;
            step_n.peer         = peer_x;
            step_n.send_blk     = s_idx;
            step_n.send_len     = sp_s.len;
            step_n.send_tail    = sp_s.tail;
            step_n.recv_blk     = r_idx;
            step_n.recv_len     = sp_r.len;
            step_n.recv_tail    = sp_r.tail;
            step_n.recv_to_temp = 1'b1;
            step_n.do_reduce    = job_ff.reduce;
            if (slot_free) begin
               send_in = r_idx;
               recv_in = r_idx;
               if (half_ff == POF_W'(1)) begin
                  mask_in  = job_ff.pof2 >> 1;
                  half_in  = POF_W'(1);
                  state_in = ST_AG;
               end else begin
                  mask_in = mask_ff << 1;
                  half_in = half_ff >> 1;
                  last_in = r_idx + half_i;
               end
            end
         end
         ST_AG: begin
            emit = 1'b1;
            if (!bit_hi) begin
               l_new = (mask_ff == (job_ff.pof2 >> 1)) ? last_ff : last_ff + half_i;
               r_idx = send_ff + half_i;
               sp_s  = span_of(send_ff, r_idx, job_ff.pof2);
               sp_r  = span_of(r_idx, l_new, job_ff.pof2);
            end else begin
               r_idx = send_ff - half_i;
               sp_s  = span_of(send_ff, last_ff, job_ff.pof2);
               sp_r  = span_of(r_idx, send_ff, job_ff.pof2);
            end
            step_n.phase     = PHASE_AG;
            step_n.peer      = peer_x;
            step_n.send_blk  = send_ff;
            step_n.send_len  = sp_s.len;
            step_n.send_tail = sp_s.tail;
            step_n.recv_blk  = r_idx;
            step_n.recv_len  = sp_r.len;
            step_n.recv_tail = sp_r.tail;
            if (slot_free) begin
               if (!bit_hi) begin
                  last_in = l_new;
                  recv_in = r_idx;
               end else begin
                  send_in = r_idx;
               end
               if (mask_ff == POF_W'(1)) begin
                  state_in = job_ff.fold_odd ? ST_POST : ST_DONE;
               end else begin
                  mask_in = mask_ff >> 1;
                  half_in = half_ff << 1;
               end
            end
         end
         ST_POST: begin
            emit         = 1'b1;
            step_n.phase = PHASE_POST;
            if (job_ff.fold_odd) begin
               step_n.peer      = job_ff.rank - RANK_W'(1);
               step_n.send_len  = pof_i;
               step_n.send_tail = 1'b1;
            end else begin
               step_n.peer      = job_ff.rank + RANK_W'(1);
               step_n.recv_len  = pof_i;
               step_n.recv_tail = 1'b1;
            end
            if (slot_free) state_in = ST_DONE;
         end
         ST_DONE: begin
            emit          = 1'b1;
            step_n.phase  = PHASE_DONE;
            step_n.status = job_ff.bad;
            step_n.last   = 1'b1;
            if (slot_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      step_valid_in = step_valid_ff;
      step_in       = step_ff;
      if (slot_free) begin
         step_valid_in = emit;
         step_in       = step_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_valid_ff <= step_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      mask_ff <= mask_in;
      half_ff <= half_in;
      send_ff <= send_in;
      recv_ff <= recv_in;
      last_ff <= last_in;
      step_ff <= step_in;
   end

endmodule

@@ src/asg_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_emit
// Output stage: scales block indices and lengths to element offsets and counts
// and holds the response register.
// ----------------------------------------------------------------------------
module asg_emit
   import asg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  step_type          step,
   output logic              step_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PHASE_W-1:0] rsp_phase,
   output logic [RANK_W-1:0] rsp_peer,
   output logic [CNT_W-1:0]  rsp_send_offset,
   output logic [CNT_W-1:0]  rsp_send_count,
   output logic [CNT_W-1:0]  rsp_recv_offset,
   output logic [CNT_W-1:0]  rsp_recv_count,
   output logic              rsp_recv_to_temp,
   output logic              rsp_do_reduce,
   output logic              rsp_status,
   output logic              rsp_last
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [RANK_W-1:0]  peer_ff, peer_in;
   logic [CNT_W-1:0]   send_offset_ff, send_offset_in;
   logic [CNT_W-1:0]   send_count_ff, send_count_in;
   logic [CNT_W-1:0]   recv_offset_ff, recv_offset_in;
   logic [CNT_W-1:0]   recv_count_ff, recv_count_in;
   logic               recv_to_temp_ff, recv_to_temp_in;
   logic               do_reduce_ff, do_reduce_in;
   logic               status_ff, status_in;
   logic               last_ff, last_in;

   logic               load;
   logic [PROD_W-1:0]  so_prod;
   logic [PROD_W-1:0]  sc_prod;
   logic [PROD_W-1:0]  ro_prod;
   logic [PROD_W-1:0]  rc_prod;
   logic [CNT_W-1:0]   r_ext;

   assign step_stall = rsp_valid_ff && rsp_stall;
   assign load       = step_valid && !step_stall;

   always_comb begin
      r_ext   = CNT_W'(step.r);
      so_prod = PROD_W'(step.send_blk) * PROD_W'(step.q);
      sc_prod = PROD_W'(step.send_len) * PROD_W'(step.q);
      ro_prod = PROD_W'(step.recv_blk) * PROD_W'(step.q);
      rc_prod = PROD_W'(step.recv_len) * PROD_W'(step.q);

      rsp_valid_in    = step_stall ? rsp_valid_ff : step_valid;
      phase_in        = phase_ff;
      peer_in         = peer_ff;
      send_offset_in  = send_offset_ff;
      send_count_in   = send_count_ff;
      recv_offset_in  = recv_offset_ff;
      recv_count_in   = recv_count_ff;
      recv_to_temp_in = recv_to_temp_ff;
      do_reduce_in    = do_reduce_ff;
      status_in       = status_ff;
      last_in         = last_ff;
      if (load) begin
         phase_in        = step.phase;
         peer_in         = step.peer;
         send_offset_in  = so_prod[CNT_W-1:0];
         send_count_in   = sc_prod[CNT_W-1:0] + (step.send_tail ? r_ext : '0);
         recv_offset_in  = ro_prod[CNT_W-1:0];
         recv_count_in   = rc_prod[CNT_W-1:0] + (step.recv_tail ? r_ext : '0);
         recv_to_temp_in = step.recv_to_temp;
         do_reduce_in    = step.do_reduce;
         status_in       = step.status;
         last_in         = step.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff        <= phase_in;
      peer_ff         <= peer_in;
      send_offset_ff  <= send_offset_in;
      send_count_ff   <= send_count_in;
      recv_offset_ff  <= recv_offset_in;
      recv_count_ff   <= recv_count_in;
      recv_to_temp_ff <= recv_to_temp_in;
      do_reduce_ff    <= do_reduce_in;
      status_ff       <= status_in;
      last_ff         <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_peer         = peer_ff;
   assign rsp_send_offset  = send_offset_ff;
   assign rsp_send_count   = send_count_ff;
   assign rsp_recv_offset  = recv_offset_ff;
   assign rsp_recv_count   = recv_count_ff;
   assign rsp_recv_to_temp = recv_to_temp_ff;
   assign rsp_do_reduce    = do_reduce_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule

@@ src/allreduce_schedule_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allreduce_schedule_generator_core
// Reduce-scatter plus allgather allreduce schedule generator with a
// power-of-two fold for excess ranks.
// ----------------------------------------------------------------------------
// Each request yields 2*log2(pof2) + 3 responses at most (pof2 the largest
// power of two not above group_size), down to a single done response for a
// bad request or a group of one. The step sequencer emits one response per
// cycle while the output does not stall and loads each request in its idle
// state before its first response. A request yields 21 responses at most:
// for a folded group of 513 to 1023 or for a full group of 1024. Requests
// are classified on intake and held in a two-entry queue, so up to two can
// wait while the sequencer works; responses leave through a registered stage.
// ----------------------------------------------------------------------------
module allreduce_schedule_generator_core
   import asg_pkg::*;
#(
   parameter int MAX_PROCS = MAX_PROCS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [GS_W-1:0]    req_group_size,
   input  logic [RANK_W-1:0]  req_my_rank,
   input  logic [CNT_W-1:0]   req_elem_count,
   input  logic               req_reduce_enable,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PHASE_W-1:0] rsp_phase,
   output logic [RANK_W-1:0]  rsp_peer,
   output logic [CNT_W-1:0]   rsp_send_offset,
   output logic [CNT_W-1:0]   rsp_send_count,
   output logic [CNT_W-1:0]   rsp_recv_offset,
   output logic [CNT_W-1:0]   rsp_recv_count,
   output logic               rsp_recv_to_temp,
   output logic               rsp_do_reduce,
   output logic               rsp_status,
   output logic               rsp_last
);

   logic     queue_full;
   logic     push;
   job_type  push_job;
   logic     job_valid;
   job_type  job;
   logic     pop;
   logic     step_valid;
   step_type step;
   logic     step_stall;

   asg_front #(
      .MAX_PROCS (MAX_PROCS)
   ) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_group_size    (req_group_size),
      .req_my_rank       (req_my_rank),
      .req_elem_count    (req_elem_count),
      .req_reduce_enable (req_reduce_enable),
      .queue_full        (queue_full),
      .push              (push),
      .push_job          (push_job)
   );

   asg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .job_valid (job_valid),
      .job       (job),
      .pop       (pop)
   );

   asg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .pop        (pop),
      .step_valid (step_valid),
      .step       (step),
      .step_stall (step_stall)
   );

   asg_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .step_valid       (step_valid),
      .step             (step),
      .step_stall       (step_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_phase        (rsp_phase),
      .rsp_peer         (rsp_peer),
      .rsp_send_offset  (rsp_send_offset),
      .rsp_send_count   (rsp_send_count),
      .rsp_recv_offset  (rsp_recv_offset),
      .rsp_recv_count   (rsp_recv_count),
      .rsp_recv_to_temp (rsp_recv_to_temp),
      .rsp_do_reduce    (rsp_do_reduce),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

@@ src/asg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asg_checker
// Port-level checks on the response stream of the schedule generator.
// ----------------------------------------------------------------------------
module asg_checker
   import asg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PHASE_W-1:0] rsp_phase,
   input logic [RANK_W-1:0]  rsp_peer,
   input logic [CNT_W-1:0]   rsp_send_offset,
   input logic [CNT_W-1:0]   rsp_send_count,
   input logic [CNT_W-1:0]   rsp_recv_offset,
   input logic [CNT_W-1:0]   rsp_recv_count,
   input logic               rsp_recv_to_temp,
   input logic               rsp_do_reduce,
   input logic               rsp_status,
   input logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase) && $stable(rsp_peer) &&
         $stable(rsp_send_offset) && $stable(rsp_send_count) &&
         $stable(rsp_recv_offset) && $stable(rsp_recv_count) &&
         $stable(rsp_recv_to_temp) && $stable(rsp_do_reduce) &&
         $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_phase == PHASE_DONE)
      else $error("last response is not a done item");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PHASE_DONE |-> rsp_last && rsp_send_count == '0 &&
         rsp_recv_count == '0)
      else $error("done item malformed");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase != PHASE_DONE |-> !rsp_status && !rsp_last)
      else $error("status or last on a schedule step");

   a_rs_to_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PHASE_RS |-> rsp_recv_to_temp)
      else $error("reduce-scatter step not received into temp");

endmodule

bind allreduce_schedule_generator_core asg_checker u_asg_checker (.*);

@@ verif/tb_allreduce_schedule_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_allreduce_schedule_generator_core
// Self-checking bench for the allreduce schedule generator. Requests go in
// through a queue-fed driver and every schedule step that comes out is checked
// field by field against an in-bench predictor of the fold, reduce-scatter,
// allgather and post-exchange sequence. Directed corner requests come first,
// then random ones, with random idling on both sides, one long output hold
// and drain pauses on the request side.
// ----------------------------------------------------------------------------
module tb_allreduce_schedule_generator_core
   import asg_pkg::*;
();

   typedef struct {
      logic [GS_W-1:0]   group_size;
      logic [RANK_W-1:0] my_rank;
      logic [CNT_W-1:0]  elem_count;
      logic              reduce_enable;
      bit                drain_first;
   } sched_req_type;

   typedef struct {
      phase_type         phase;
      logic [RANK_W-1:0] peer;
      logic [CNT_W-1:0]  send_offset;
      logic [CNT_W-1:0]  send_count;
      logic [CNT_W-1:0]  recv_offset;
      logic [CNT_W-1:0]  recv_count;
      logic              recv_to_temp;
      logic              do_reduce;
      logic              status;
      logic              last;
   } sched_step_type;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [GS_W-1:0]    req_group_size = '0;
   logic [RANK_W-1:0]  req_my_rank = '0;
   logic [CNT_W-1:0]   req_elem_count = '0;
   logic               req_reduce_enable = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PHASE_W-1:0] rsp_phase;
   logic [RANK_W-1:0]  rsp_peer;
   logic [CNT_W-1:0]   rsp_send_offset;
   logic [CNT_W-1:0]   rsp_send_count;
   logic [CNT_W-1:0]   rsp_recv_offset;
   logic [CNT_W-1:0]   rsp_recv_count;
   logic               rsp_recv_to_temp;
   logic               rsp_do_reduce;
   logic               rsp_status;
   logic               rsp_last;

   sched_req_type  pending_requests[$];
   sched_step_type expected_steps[$];
   sched_req_type  drive_item;

   int          requests_accepted = 0;
   int          failures = 0;
   int          reported = 0;
   bit          req_taken = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_cycles = 0;
   bit          hold_done = 1'b0;
   logic [31:0] cycle_count = '0;
   wire         quiet = (cycle_count[8:7] == 2'b11);

   allreduce_schedule_generator_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_group_size    (req_group_size),
      .req_my_rank       (req_my_rank),
      .req_elem_count    (req_elem_count),
      .req_reduce_enable (req_reduce_enable),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_phase         (rsp_phase),
      .rsp_peer          (rsp_peer),
      .rsp_send_offset   (rsp_send_offset),
      .rsp_send_count    (rsp_send_count),
      .rsp_recv_offset   (rsp_recv_offset),
      .rsp_recv_count    (rsp_recv_count),
      .rsp_recv_to_temp  (rsp_recv_to_temp),
      .rsp_do_reduce     (rsp_do_reduce),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 20);
   endfunction

   // Element offset of block i.
   function automatic logic [CNT_W-1:0] block_start(int unsigned i, int unsigned q);
      logic [63:0] v;
      v = 64'(i) * 64'(q);
      return v[CNT_W-1:0];
   endfunction

   // Elements held by blocks [a, b), the final block carrying the remainder.
   function automatic logic [CNT_W-1:0] block_span(int unsigned a, int unsigned b,
                                                    int unsigned nblk, int unsigned q,
                                                    int unsigned tail_len);
      int unsigned bc;
      logic [63:0] s;
      bc = (b > nblk) ? nblk : b;
      if (bc <= a) return '0;
      if (bc == nblk) s = 64'(bc - a - 1) * 64'(q) + 64'(tail_len);
      else s = 64'(bc - a) * 64'(q);
      return s[CNT_W-1:0];
   endfunction

   task automatic push_step(phase_type ph, int unsigned peer, logic [CNT_W-1:0] so,
                            logic [CNT_W-1:0] sc, logic [CNT_W-1:0] ro,
                            logic [CNT_W-1:0] rc, logic tmp, logic red,
                            logic st, logic lst);
      sched_step_type s;
      s.phase        = ph;
      s.peer         = RANK_W'(peer);
      s.send_offset  = so;
      s.send_count   = sc;
      s.recv_offset  = ro;
      s.recv_count   = rc;
      s.recv_to_temp = tmp;
      s.do_reduce    = red;
      s.status       = st;
      s.last         = lst;
      expected_steps.push_back(s);
   endtask

   task automatic predict_schedule(sched_req_type rq);
      int unsigned n, rank, count, pof2, rem, q, tail_len, nr;
      int unsigned mask, sidx, ridx, lidx, newdst, dst;
      logic [CNT_W-1:0] sc, rc;
      logic red;
      bit active;
      n     = rq.group_size;
      rank  = rq.my_rank;
      count = rq.elem_count;
      red   = rq.reduce_enable;
      if (n == 0 || n > MAX_PROCS_DEF || rank >= n) begin
         push_step(PHASE_DONE, 0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
         return;
      end
      pof2 = 1;
      while (pof2 <= n) pof2 = pof2 << 1;
      pof2 = pof2 >> 1;
      rem      = n - pof2;
      q        = count / pof2;
      tail_len = (count - q * (pof2 - 1)) & 32'h7FFF_FFFF;
      active   = 1'b1;
      nr       = rank - rem;
      if (rank < 2 * rem) begin
         if (rank[0] == 1'b0) begin
            push_step(PHASE_PRE, rank + 1, '0, CNT_W'(count), '0, '0, 1'b0, 1'b0,
                      1'b0, 1'b0);
            active = 1'b0;
         end else begin
            push_step(PHASE_PRE, rank - 1, '0, '0, '0, CNT_W'(count), 1'b1, red,
                      1'b0, 1'b0);
            nr = rank / 2;
         end
      end
      if (active) begin
         mask = 1;
         sidx = 0;
         ridx = 0;
         lidx = pof2;
         while (mask < pof2) begin
            newdst = nr ^ mask;
            dst    = (newdst < rem) ? newdst * 2 + 1 : newdst + rem;
            if (nr < newdst) begin
               sidx = ridx + pof2 / (mask * 2);
               sc   = block_span(sidx, lidx, pof2, q, tail_len);
               rc   = block_span(ridx, sidx, pof2, q, tail_len);
            end else begin
               ridx = sidx + pof2 / (mask * 2);
               sc   = block_span(sidx, ridx, pof2, q, tail_len);
               rc   = block_span(ridx, lidx, pof2, q, tail_len);
            end
            push_step(PHASE_RS, dst, block_start(sidx, q), sc, block_start(ridx, q), rc,
                      1'b1, red, 1'b0, 1'b0);
            sidx = ridx;
            mask = mask << 1;
            if (mask < pof2) lidx = ridx + pof2 / mask;
         end
         mask = mask >> 1;
         while (mask > 0) begin
            newdst = nr ^ mask;
            dst    = (newdst < rem) ? newdst * 2 + 1 : newdst + rem;
            if (nr < newdst) begin
               if (mask != pof2 / 2) lidx = lidx + pof2 / (mask * 2);
               ridx = sidx + pof2 / (mask * 2);
               sc   = block_span(sidx, ridx, pof2, q, tail_len);
               rc   = block_span(ridx, lidx, pof2, q, tail_len);
            end else begin
               ridx = sidx - pof2 / (mask * 2);
               sc   = block_span(sidx, lidx, pof2, q, tail_len);
               rc   = block_span(ridx, sidx, pof2, q, tail_len);
            end
            push_step(PHASE_AG, dst, block_start(sidx, q), sc, block_start(ridx, q), rc,
                      1'b0, 1'b0, 1'b0, 1'b0);
            if (nr > newdst) sidx = ridx;
            mask = mask >> 1;
         end
      end
      if (rank < 2 * rem) begin
         if (rank[0])
            push_step(PHASE_POST, rank - 1, '0, CNT_W'(count), '0, '0, 1'b0, 1'b0,
                      1'b0, 1'b0);
         else
            push_step(PHASE_POST, rank + 1, '0, '0, '0, CNT_W'(count), 1'b0, 1'b0,
                      1'b0, 1'b0);
      end
      push_step(PHASE_DONE, 0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
   endtask

   task automatic add_request(int unsigned gs, int unsigned rank, logic [CNT_W-1:0] cnt,
                              logic red, bit drain);
      sched_req_type r;
      r.group_size    = GS_W'(gs);
      r.my_rank       = RANK_W'(rank);
      r.elem_count    = cnt;
      r.reduce_enable = red;
      r.drain_first   = drain;
      pending_requests.push_back(r);
   endtask

   task automatic add_random_request(bit drain);
      int unsigned n, rank, k, sel;
      logic [CNT_W-1:0] cnt;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         case ($urandom_range(0, 2))
            0: begin
               n    = 0;
               rank = $urandom_range(0, 1023);
            end
            1: begin
               n    = $urandom_range(MAX_PROCS_DEF + 1, 2047);
               rank = $urandom_range(0, 1023);
            end
            default: begin
               n    = $urandom_range(1, 1023);
               rank = $urandom_range(n, 1023);
            end
         endcase
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 40) n = $urandom_range(2, 16);
         else if (sel < 70) n = $urandom_range(17, MAX_PROCS_DEF);
         else if (sel < 90) begin
            k = $urandom_range(1, 10);
            n = (1 << k) + $urandom_range(0, 2) - 1;
            if (n > MAX_PROCS_DEF) n = MAX_PROCS_DEF;
         end else n = $urandom_range(1, MAX_PROCS_DEF);
         rank = $urandom_range(0, n - 1);
      end
      sel = $urandom_range(0, 99);
      if (sel < 30) cnt = CNT_W'($urandom_range(0, 64));
      else if (sel < 60) cnt = CNT_W'($urandom);
      else if (sel < 80) cnt = CNT_W'($urandom_range(0, 4096));
      else if (sel < 90) cnt = CNT_MAX - CNT_W'($urandom_range(0, 1024));
      else cnt = CNT_MAX;
      add_request(n, rank, cnt, 1'($urandom_range(0, 1)), drain);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // request side: predict on acceptance
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         predict_schedule('{req_group_size, req_my_rank, req_elem_count,
                            req_reduce_enable, 1'b0});
         requests_accepted++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_requests[0].drain_first && expected_steps.size() != 0) begin
            req_valid <= 1'b0;
         end else begin
            drive_item = pending_requests.pop_front();
            req_group_size    <= drive_item.group_size;
            req_my_rank       <= drive_item.my_rank;
            req_elem_count    <= drive_item.elem_count;
            req_reduce_enable <= drive_item.reduce_enable;
            req_valid         <= 1'b1;
            send_gap = quiet ? 0 : pick_gap();
         end
      end
   end

   // response side: random stalls plus one long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && requests_accepted >= 60) begin
         hold_done   = 1'b1;
         hold_cycles = 300;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      sched_step_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steps.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: unexpected step phase=%0d peer=%0d status=%0b last=%0b",
                        rsp_phase, rsp_peer, rsp_status, rsp_last);
            end
         end else begin
            e = expected_steps.pop_front();
            if (rsp_phase !== e.phase || rsp_peer !== e.peer ||
                rsp_send_offset !== e.send_offset || rsp_send_count !== e.send_count ||
                rsp_recv_offset !== e.recv_offset || rsp_recv_count !== e.recv_count ||
                rsp_recv_to_temp !== e.recv_to_temp || rsp_do_reduce !== e.do_reduce ||
                rsp_status !== e.status || rsp_last !== e.last) begin
               failures++;
               if (reported < 10) begin
                  reported++;
                  $display("ERROR: step mismatch at %0t", $realtime);
                  $display("  exp ph=%0d peer=%0d so=%0d sc=%0d ro=%0d rc=%0d t=%0b r=%0b s=%0b l=%0b",
                           e.phase, e.peer, e.send_offset, e.send_count, e.recv_offset,
                           e.recv_count, e.recv_to_temp, e.do_reduce, e.status, e.last);
                  $display("  got ph=%0d peer=%0d so=%0d sc=%0d ro=%0d rc=%0d t=%0b r=%0b s=%0b l=%0b",
                           rsp_phase, rsp_peer, rsp_send_offset, rsp_send_count,
                           rsp_recv_offset, rsp_recv_count, rsp_recv_to_temp,
                           rsp_do_reduce, rsp_status, rsp_last);
               end
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("allreduce_schedule_generator_core verification failed");
      $finish;
   end

   initial begin
      // bad requests and a group of one
      add_request(0, 0, 100, 1'b1, 1'b0);
      add_request(1, 0, 0, 1'b1, 1'b0);
      add_request(1, 1, 5, 1'b0, 1'b0);
      add_request(MAX_PROCS_DEF + 1, 0, 7, 1'b1, 1'b0);
      add_request(2047, 1023, CNT_MAX, 1'b1, 1'b0);
      add_request(16, 16, 1, 1'b0, 1'b0);
      add_request(600, 1023, 1, 1'b1, 1'b0);
      // fold even, fold odd, unfolded
      add_request(2, 0, 10, 1'b1, 1'b0);
      add_request(2, 1, 10, 1'b0, 1'b0);
      add_request(3, 0, 9, 1'b1, 1'b0);
      add_request(3, 1, 9, 1'b1, 1'b0);
      add_request(3, 2, 9, 1'b0, 1'b0);
      add_request(5, 1, 17, 1'b1, 1'b0);
      add_request(5, 4, 17, 1'b1, 1'b0);
      // full groups, extreme counts, counts below pof2
      add_request(MAX_PROCS_DEF, 0, CNT_MAX, 1'b1, 1'b0);
      add_request(MAX_PROCS_DEF, 1023, 0, 1'b1, 1'b0);
      add_request(MAX_PROCS_DEF, 512, 1000, 1'b0, 1'b0);
      add_request(1023, 0, 5, 1'b1, 1'b0);
      add_request(1023, 1, 5, 1'b1, 1'b0);
      add_request(1023, 1021, CNT_MAX, 1'b1, 1'b0);
      add_request(1023, 1022, 12345, 1'b0, 1'b0);
      add_request(8, 7, 3, 1'b1, 1'b0);
      add_request(8, 3, 0, 1'b0, 1'b0);
      add_request(1000, 999, 1, 1'b1, 1'b0);
      for (int i = 0; i < 350; i++) add_random_request(i % 90 == 89);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_valid || expected_steps.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (expected_steps.size() != 0) failures++;
      if (failures == 0)
         $display("allreduce_schedule_generator_core verification clean");
      else
         $display("allreduce_schedule_generator_core verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
src/asg_pkg.sv
src/asg_front.sv
src/asg_queue.sv
src/asg_back.sv
src/asg_emit.sv
src/allreduce_schedule_generator_core.sv
src/asg_checker.sv
verif/tb_allreduce_schedule_generator_core.sv
